// ----- hdl/fdr_pkg.sv -----
// Shared constants and sideband types for the Fresnel reflectance core.
// No dependencies.
package fdr_pkg;

  localparam int COS_W  = 16;  // signed Q2.14 cosine
  localparam int ETA_W  = 16;  // unsigned Q4.12 index
  localparam int REFL_W = 17;  // unsigned Q1.16 reflectance
  localparam int MAG_W  = 16;  // |cosine|, up to 32768

  localparam int SIN_W    = 15;  // Q14 sine / cosine, up to 16384
  localparam int RAD_W    = 30;  // square root radicand (even width)
  localparam int ET2_W    = 32;  // eta_t squared
  localparam int NUM_W    = 60;  // eta_t^2 * 2^28 - lhs^2
  localparam int COST2_W  = 29;  // cos_t squared, up to 2^28
  localparam int PROD_W   = 32;  // eta * cosine products
  localparam int SUM_W    = 33;
  localparam int RQ_W     = 25;  // Q24 ratio, up to 2^24
  localparam int RNUM_W   = SUM_W + 24;

  localparam logic [REFL_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic REG_ETA_INCIDENT    = 1'b0;
  localparam logic REG_ETA_TRANSMITTED = 1'b1;

  localparam logic [ETA_W-1:0] ETA_I_RESET = 16'd4096;
  localparam logic [ETA_W-1:0] ETA_T_RESET = 16'd6144;

  typedef struct packed {
    logic [MAG_W-1:0] c;
    logic [ETA_W-1:0] ei;
    logic [ETA_W-1:0] et;
  } side_geo_t;

  typedef struct packed {
    logic [MAG_W-1:0] c;
    logic [ETA_W-1:0] ei;
    logic [ETA_W-1:0] et;
    logic             tir;
  } side_tir_t;

  typedef struct packed {
    logic tir;
    logic zero_den;
  } side_flag_t;

endpackage

// ----- hdl/fdr_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Sideband bits travel with each item. No package dependency.
module fdr_sqrt #(
  parameter int STEPS  = 15,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2*STEPS-1:0]  radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [STEPS-1:0]    root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW = STEPS + 2;

  logic [RW-1:0]       rem_q  [STEPS];
  logic [STEPS-1:0]    root_q [STEPS];
  logic [2*STEPS-1:0]  x_q    [STEPS];
  logic [SIDE_W-1:0]   side_q [STEPS];
  logic [STEPS-1:0]    valid_q;

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [RW-1:0]      rem_in, rem_sh, trial, rem_next;
    logic [STEPS-1:0]   root_in, root_next;
    logic [2*STEPS-1:0] x_in;
    logic [SIDE_W-1:0]  side_in;
    logic               v_in, ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = radicand;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = valid_q[s-1];
    end

    always_comb begin
      rem_sh    = {rem_in[RW-3:0], x_in[2*(STEPS-1-s) +: 2]};
      trial     = {root_in, 2'b01};
      ge        = (rem_sh >= trial);
      rem_next  = ge ? (rem_sh - trial) : rem_sh;
      root_next = {root_in[STEPS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
      rem_q[s]  <= rem_next;
      root_q[s] <= root_next;
      x_q[s]    <= x_in;
      side_q[s] <= side_in;
    end
  end

  assign out_valid = valid_q[STEPS-1];
  assign root      = root_q[STEPS-1];
  assign out_side  = side_q[STEPS-1];

endmodule

// ----- hdl/fdr_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Caller guarantees num >> Q_W < den. No package dependency.
module fdr_div #(
  parameter int NUM_W  = 60,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 29,
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic [Q_W-1:0]     quot,
  output logic [SIDE_W-1:0]  out_side
);

  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    q_q    [Q_W];
  logic [Q_W-1:0]    lo_q   [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic [Q_W-1:0]    valid_q;

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DEN_W-1:0]  rem_in, den_in, rem_next;
    logic [DEN_W:0]    rem_sh, diff;
    logic [Q_W-1:0]    q_in, lo_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in, ge;

    if (s == 0) begin : g_first
      assign rem_in  = DEN_W'(num[NUM_W-1:Q_W]);
      assign q_in    = '0;
      assign lo_in   = num[Q_W-1:0];
      assign den_in  = den;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign q_in    = q_q[s-1];
      assign lo_in   = lo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign v_in    = valid_q[s-1];
    end

    always_comb begin
      rem_sh   = {rem_in, lo_in[Q_W-1-s]};
      diff     = rem_sh - {1'b0, den_in};
      ge       = (rem_sh >= {1'b0, den_in});
      rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
      rem_q[s]  <= rem_next;
      q_q[s]    <= {q_in[Q_W-2:0], ge};
      lo_q[s]   <= lo_in;
      den_q[s]  <= den_in;
      side_q[s] <= side_in;
    end
  end

  assign out_valid = valid_q[Q_W-1];
  assign quot      = q_q[Q_W-1];
  assign out_side  = side_q[Q_W-1];

endmodule

// ----- hdl/fresnel_dielectric_reflectance_core.sv -----
// Top level of the unpolarized dielectric Fresnel reflectance core.
// Uses fdr_pkg, fdr_sqrt and fdr_div.
//
// Usage:
//   Pulse start with cos_incident (signed Q2.14) to issue a transaction.
//   busy is always low, so one transaction can be issued every cycle.
//   Each result shows up on reflectance (Q1.16) and total_reflection with
//   done high for exactly one cycle, in issue order.
//   The pipeline holds 94 registers; the last of them drives done.
//   Throughput is one transaction per cycle. The depth is set by the
//   bit-per-stage units: two 15-stage square roots, a 29-stage divider and
//   two parallel 25-stage ratio dividers, plus multiply and add stages.
//   The receiver has no backpressure; results must be taken when done is high.
//   Indices are written over the APB port (eta_incident at 0, eta_transmitted
//   at 4) and are sampled when a transaction is accepted; change them only
//   with no transaction in flight.
//   Synchronous reset clears all valid bits (nothing in flight) and sets the
//   indices to 1.0 and 1.5.
module fresnel_dielectric_reflectance_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [fdr_pkg::COS_W-1:0] cos_incident,
  output logic                         done,
  output logic [fdr_pkg::REFL_W-1:0]   reflectance,
  output logic                         total_reflection,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int ETA_W = fdr_pkg::ETA_W;
  localparam int MAG_W = fdr_pkg::MAG_W;
  localparam int SIN_W = fdr_pkg::SIN_W;
  localparam int RAD_W = fdr_pkg::RAD_W;

  // ---------------- configuration ----------------
  logic [ETA_W-1:0] eta_incident, eta_transmitted;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_incident    <= fdr_pkg::ETA_I_RESET;
      eta_transmitted <= fdr_pkg::ETA_T_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == fdr_pkg::REG_ETA_INCIDENT) begin
        eta_incident <= pwdata[ETA_W-1:0];
      end else begin
        eta_transmitted <= pwdata[ETA_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == fdr_pkg::REG_ETA_INCIDENT) ? 32'(eta_incident)
                                                         : 32'(eta_transmitted);

  // ---------------- stage A: fold sign, swap indices ----------------
  logic             a_valid;
  logic [MAG_W-1:0] a_c;
  logic [ETA_W-1:0] a_ei, a_et;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    if (cos_incident[fdr_pkg::COS_W-1]) begin
      a_c  <= MAG_W'(16'h0 - cos_incident);
      a_ei <= eta_transmitted;
      a_et <= eta_incident;
    end else begin
      a_c  <= MAG_W'(cos_incident);
      a_ei <= eta_incident;
      a_et <= eta_transmitted;
    end
  end

  // ---------------- stage B: c squared ----------------
  logic             b_valid;
  logic [31:0]      b_c2;
  fdr_pkg::side_geo_t b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_c2      <= 32'(a_c) * 32'(a_c);
    b_side.c  <= a_c;
    b_side.ei <= a_ei;
    b_side.et <= a_et;
  end

  // ---------------- stage C: 1 - c^2 clamped at zero ----------------
  logic               c_valid;
  logic [RAD_W-1:0]   c_rad;
  fdr_pkg::side_geo_t c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
    if (b_c2 >= 32'h1000_0000) begin
      c_rad <= '0;
    end else begin
      c_rad <= RAD_W'(32'h1000_0000 - b_c2);
    end
    c_side <= b_side;
  end

  // ---------------- sine of incidence ----------------
  logic               s1_valid;
  logic [SIN_W-1:0]   s1_sin;
  logic [$bits(fdr_pkg::side_geo_t)-1:0] s1_side_raw;
  fdr_pkg::side_geo_t s1_side;

  fdr_sqrt #(.STEPS(SIN_W), .SIDE_W($bits(fdr_pkg::side_geo_t))) u_sqrt_sin (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .radicand  (c_rad),
    .in_side   (c_side),
    .out_valid (s1_valid),
    .root      (s1_sin),
    .out_side  (s1_side_raw)
  );
  assign s1_side = fdr_pkg::side_geo_t'(s1_side_raw);

  // ---------------- stage D: eta_i * sin_i, eta_t^2 ----------------
  logic                   d_valid;
  logic [30:0]            d_lhs;
  logic [fdr_pkg::ET2_W-1:0] d_et2;
  fdr_pkg::side_geo_t     d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= s1_valid;
    end
    d_lhs  <= 31'(s1_side.ei) * 31'(s1_sin);
    d_et2  <= 32'(s1_side.et) * 32'(s1_side.et);
    d_side <= s1_side;
  end

  // ---------------- stage E: TIR compare, lhs squared ----------------
  logic                      e_valid;
  logic [61:0]               e_lhs2;
  logic [fdr_pkg::ET2_W-1:0] e_et2;
  fdr_pkg::side_tir_t        e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
    e_lhs2     <= 62'(d_lhs) * 62'(d_lhs);
    e_et2      <= d_et2;
    e_side.c   <= d_side.c;
    e_side.ei  <= d_side.ei;
    e_side.et  <= d_side.et;
    e_side.tir <= ({1'b0, d_lhs} >= {2'b0, d_side.et, 14'b0});
  end

  // ---------------- stage F: numerator of cos_t^2 ----------------
  logic                      f_valid;
  logic [fdr_pkg::NUM_W-1:0] f_num;
  logic [fdr_pkg::ET2_W-1:0] f_et2;
  fdr_pkg::side_tir_t        f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
    f_num  <= {e_et2, 28'b0} - e_lhs2[fdr_pkg::NUM_W-1:0];
    f_et2  <= e_et2;
    f_side <= e_side;
  end

  // ---------------- cos_t^2 = num / eta_t^2 ----------------
  logic                        q_valid;
  logic [fdr_pkg::COST2_W-1:0] q_cost2;
  logic [$bits(fdr_pkg::side_tir_t)-1:0] q_side;

  fdr_div #(
    .NUM_W  (fdr_pkg::NUM_W),
    .DEN_W  (fdr_pkg::ET2_W),
    .Q_W    (fdr_pkg::COST2_W),
    .SIDE_W ($bits(fdr_pkg::side_tir_t))
  ) u_div_cost2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_et2),
    .in_side   (f_side),
    .out_valid (q_valid),
    .quot      (q_cost2),
    .out_side  (q_side)
  );

  // ---------------- cos_t ----------------
  logic               s2_valid;
  logic [SIN_W-1:0]   s2_cos;
  logic [$bits(fdr_pkg::side_tir_t)-1:0] s2_side_raw;
  fdr_pkg::side_tir_t s2_side;

  fdr_sqrt #(.STEPS(SIN_W), .SIDE_W($bits(fdr_pkg::side_tir_t))) u_sqrt_cos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .radicand  (RAD_W'(q_cost2)),
    .in_side   (q_side),
    .out_valid (s2_valid),
    .root      (s2_cos),
    .out_side  (s2_side_raw)
  );
  assign s2_side = fdr_pkg::side_tir_t'(s2_side_raw);

  // ---------------- stage G: cross products ----------------
  localparam int PW = fdr_pkg::PROD_W;
  localparam int SW = fdr_pkg::SUM_W;

  logic          g_valid, g_tir;
  logic [PW-1:0] g_a, g_b, g_d, g_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= s2_valid;
    end
    g_a   <= PW'(s2_side.et) * PW'(s2_side.c);
    g_b   <= PW'(s2_side.ei) * PW'(s2_cos);
    g_d   <= PW'(s2_side.ei) * PW'(s2_side.c);
    g_e   <= PW'(s2_side.et) * PW'(s2_cos);
    g_tir <= s2_side.tir;
  end

  // ---------------- stage H: sums and differences ----------------
  logic               h_valid;
  logic [SW-1:0]      h_sum1, h_sum2, h_dif1, h_dif2;
  fdr_pkg::side_flag_t h_side;
  logic [SW-1:0]      sum1, sum2;

  assign sum1 = SW'(g_a) + SW'(g_b);
  assign sum2 = SW'(g_d) + SW'(g_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else begin
      h_valid <= g_valid;
    end
    h_sum1 <= sum1;
    h_sum2 <= sum2;
    h_dif1 <= (g_a >= g_b) ? SW'(g_a - g_b) : SW'(g_b - g_a);
    h_dif2 <= (g_d >= g_e) ? SW'(g_d - g_e) : SW'(g_e - g_d);
    h_side.tir      <= g_tir;
    h_side.zero_den <= (sum1 == '0) || (sum2 == '0);
  end

  // ---------------- Q24 amplitude ratios ----------------
  logic                     r_valid;
  logic [fdr_pkg::RQ_W-1:0] r_q1, r_q2;
  logic [$bits(fdr_pkg::side_flag_t)-1:0] r_side_raw;
  fdr_pkg::side_flag_t      r_side;

  fdr_div #(
    .NUM_W  (fdr_pkg::RNUM_W),
    .DEN_W  (SW),
    .Q_W    (fdr_pkg::RQ_W),
    .SIDE_W ($bits(fdr_pkg::side_flag_t))
  ) u_div_par (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .num       ({h_dif1, 24'b0}),
    .den       (h_sum1),
    .in_side   (h_side),
    .out_valid (r_valid),
    .quot      (r_q1),
    .out_side  (r_side_raw)
  );
  assign r_side = fdr_pkg::side_flag_t'(r_side_raw);

  fdr_div #(
    .NUM_W  (fdr_pkg::RNUM_W),
    .DEN_W  (SW),
    .Q_W    (fdr_pkg::RQ_W),
    .SIDE_W (1)
  ) u_div_perp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .num       ({h_dif2, 24'b0}),
    .den       (h_sum2),
    .in_side   (1'b0),
    .out_valid (),
    .quot      (r_q2),
    .out_side  ()
  );

  // ---------------- stage I: squares ----------------
  logic                i_valid;
  logic [49:0]         i_sq1, i_sq2;
  fdr_pkg::side_flag_t i_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else begin
      i_valid <= r_valid;
    end
    i_sq1  <= 50'(r_q1) * 50'(r_q1);
    i_sq2  <= 50'(r_q2) * 50'(r_q2);
    i_side <= r_side;
  end

  // ---------------- stage J: mean, round, saturate ----------------
  logic [50:0] total;
  logic [17:0] mean;

  assign total = 51'(i_sq1) + 51'(i_sq2) + 51'h1_0000_0000;
  assign mean  = total[50:33];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= i_valid;
    end
    total_reflection <= i_side.tir;
    if (i_side.tir || i_side.zero_den || (mean > 18'(fdr_pkg::ONE_Q16))) begin
      reflectance <= fdr_pkg::ONE_Q16;
    end else begin
      reflectance <= mean[fdr_pkg::REFL_W-1:0];
    end
  end

endmodule
